@@ rtl/fmbs_pkg.sv @@
// Shared types, codes and constants for the FLAC metadata block scanner.
package fmbs_pkg;

    // Scan phase
    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_HEADER = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_COMMENT  = 3'd0;
    localparam logic [2:0] KIND_PICTURES = 3'd1;
    localparam logic [2:0] KIND_ERROR    = 3'd2;
    localparam logic [2:0] KIND_FINISHED = 3'd3;
    localparam logic [2:0] KIND_NOT_FLAC = 3'd4;

    // Metadata block types
    localparam logic [6:0] T_STREAMINFO = 7'd0;
    localparam logic [6:0] T_COMMENT    = 7'd4;
    localparam logic [6:0] T_PICTURE    = 7'd6;
    localparam logic [6:0] T_INVALID    = 7'd127;

    // Bit of the first header byte that flags the last metadata block
    localparam int LAST_BIT_POS = 7;

    // "fLaC"
    localparam logic [7:0] FLAC_MAGIC [4] = '{8'h66, 8'h4C, 8'h61, 8'h43};

    // Result queue depth and occupancy width
    localparam int Q_DEPTH = 3;
    localparam int LEVEL_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic        last;
    } result_t;

    // Up to two results from one byte, in order
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_push_t;

endpackage

@@ rtl/fmbs_core.sv @@
// Scan state and per-byte decode of the FLAC metadata block scanner.
module fmbs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                stream_start,
    input  logic [31:0]         stream_length,
    output fmbs_pkg::res_push_t push,
    output logic                scan_done
);

    fmbs_pkg::phase_t phase_reg, phase_next, eff_phase, phase_pre;
    logic [1:0]  idx_reg, idx_next, eff_idx;
    logic [31:0] pos_reg, pos_next, eff_pos;
    logic [6:0]  type_reg, type_next, eff_type;
    logic        lastf_reg, lastf_next, eff_lastf;
    logic [23:0] acc_reg, acc_next, eff_acc;
    logic [23:0] skip_reg, skip_next, eff_skip;
    logic        pics_reg, pics_next, eff_pics;
    logic        first_reg, first_next, eff_first;

    logic        active, in_magic, in_hdr, in_skip;
    logic [32:0] nxt;
    logic        eos;
    logic        magic_bad, hdr_done, bad_type, oversize;
    logic        type_fail, size_fail, hdr_ok, comment, picture;
    logic [23:0] size, skip_dec;
    logic        skip_end, body_end, finish, stop;
    logic        eos_hit, eos_magic, eos_fail, pics_now, final_v;
    fmbs_pkg::result_t cmt_res, fin_res;

    // A restart beat sees the reset state
    always_comb
    begin
        if (stream_start)
        begin
            eff_phase = fmbs_pkg::PH_MAGIC;
            eff_idx   = 2'd0;
            eff_pos   = 32'd0;
            eff_type  = 7'd0;
            eff_lastf = 1'b0;
            eff_acc   = 24'd0;
            eff_skip  = 24'd0;
            eff_pics  = 1'b0;
            eff_first = 1'b1;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_idx   = idx_reg;
            eff_pos   = pos_reg;
            eff_type  = type_reg;
            eff_lastf = lastf_reg;
            eff_acc   = acc_reg;
            eff_skip  = skip_reg;
            eff_pics  = pics_reg;
            eff_first = first_reg;
        end
    end

    // Event decode
    always_comb
    begin
        active   = (eff_phase != fmbs_pkg::PH_DONE);
        in_magic = (eff_phase == fmbs_pkg::PH_MAGIC);
        in_hdr   = (eff_phase == fmbs_pkg::PH_HEADER);
        in_skip  = (eff_phase == fmbs_pkg::PH_SKIP);
        nxt      = {1'b0, eff_pos} + 33'd1;
        eos      = (nxt >= {1'b0, stream_length});

        magic_bad = in_magic && (data_byte != fmbs_pkg::FLAC_MAGIC[eff_idx]);
        hdr_done  = in_hdr && (eff_idx == 2'd3);
        size      = {eff_acc[15:0], data_byte};
        bad_type  = eff_first ? (eff_type != fmbs_pkg::T_STREAMINFO)
                              : ((eff_type == fmbs_pkg::T_STREAMINFO) ||
                                 (eff_type == fmbs_pkg::T_INVALID));
        // size > length - nxt - 4, rearranged to stay unsigned
        oversize  = ({10'd0, size} + {1'b0, nxt} + 34'd4) > {2'd0, stream_length};

        type_fail = hdr_done && bad_type;
        size_fail = hdr_done && !bad_type && oversize;
        hdr_ok    = hdr_done && !bad_type && !oversize;
        comment   = hdr_ok && !eff_first && (eff_type == fmbs_pkg::T_COMMENT);
        picture   = hdr_ok && !eff_first && (eff_type == fmbs_pkg::T_PICTURE);

        skip_dec  = eff_skip - 24'd1;
        skip_end  = in_skip && (skip_dec == 24'd0);
        body_end  = (hdr_ok && (size == 24'd0)) || skip_end;
        finish    = body_end && (eff_lastf || eos);
        stop      = magic_bad || type_fail || size_fail || finish;
        pics_now  = eff_pics || picture;

        unique case (eff_phase)
            fmbs_pkg::PH_MAGIC:
                phase_pre = (eff_idx == 2'd3) ? fmbs_pkg::PH_HEADER : fmbs_pkg::PH_MAGIC;
            fmbs_pkg::PH_HEADER:
                phase_pre = (hdr_ok && (size != 24'd0)) ? fmbs_pkg::PH_SKIP
                                                         : fmbs_pkg::PH_HEADER;
            fmbs_pkg::PH_SKIP:
                phase_pre = skip_end ? fmbs_pkg::PH_HEADER : fmbs_pkg::PH_SKIP;
            fmbs_pkg::PH_DONE:
                phase_pre = fmbs_pkg::PH_DONE;
        endcase
        if (stop)
        begin
            phase_pre = fmbs_pkg::PH_DONE;
        end

        // Stream runs out with the scan still open
        eos_hit   = active && !stop && eos;
        eos_magic = eos_hit && (phase_pre == fmbs_pkg::PH_MAGIC);
        eos_fail  = eos_hit && (phase_pre != fmbs_pkg::PH_MAGIC);
        final_v   = stop || eos_hit;
    end

    // Next state
    always_comb
    begin
        phase_next = eos_hit ? fmbs_pkg::PH_DONE : phase_pre;
        idx_next   = (in_magic || in_hdr) ? (eff_idx + 2'd1) : eff_idx;
        pos_next   = active ? nxt[31:0] : eff_pos;
        type_next  = eff_type;
        lastf_next = eff_lastf;
        acc_next   = eff_acc;
        if (in_hdr)
        begin
            if (eff_idx == 2'd0)
            begin
                type_next  = data_byte[6:0];
                lastf_next = data_byte[fmbs_pkg::LAST_BIT_POS];
                acc_next   = 24'd0;
            end
            else
            begin
                acc_next = size;
            end
        end
        if (hdr_ok)
        begin
            skip_next = size;
        end
        else if (in_skip)
        begin
            skip_next = skip_dec;
        end
        else
        begin
            skip_next = eff_skip;
        end
        pics_next  = pics_now;
        first_next = hdr_ok ? 1'b0 : eff_first;
    end

    // Results
    always_comb
    begin
        cmt_res.kind   = fmbs_pkg::KIND_COMMENT;
        cmt_res.offset = nxt[31:0];
        cmt_res.length = {8'd0, size};
        cmt_res.last   = 1'b0;

        fin_res.offset = 32'd0;
        fin_res.length = 32'd0;
        fin_res.last   = 1'b1;
        if (magic_bad || eos_magic)
        begin
            fin_res.kind = fmbs_pkg::KIND_NOT_FLAC;
        end
        else if (type_fail || size_fail || eos_fail)
        begin
            fin_res.kind = fmbs_pkg::KIND_ERROR;
            if (type_fail)
            begin
                fin_res.offset = eff_pos - 32'd3;
            end
            else if (size_fail)
            begin
                fin_res.offset = eff_pos - 32'd2;
            end
            else
            begin
                fin_res.offset = nxt[31:0];
            end
        end
        else if (pics_now)
        begin
            fin_res.kind   = fmbs_pkg::KIND_PICTURES;
            fin_res.length = stream_length;
        end
        else
        begin
            fin_res.kind = fmbs_pkg::KIND_FINISHED;
        end

        push.v0 = accept && (comment || final_v);
        push.v1 = accept && comment && final_v;
        push.r0 = comment ? cmt_res : fin_res;
        push.r1 = fin_res;
    end

    assign scan_done = (phase_reg == fmbs_pkg::PH_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fmbs_pkg::PH_MAGIC;
            idx_reg   <= 2'd0;
            pos_reg   <= 32'd0;
            type_reg  <= 7'd0;
            lastf_reg <= 1'b0;
            acc_reg   <= 24'd0;
            skip_reg  <= 24'd0;
            pics_reg  <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            lastf_reg <= lastf_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            pics_reg  <= pics_next;
            first_reg <= first_next;
        end
    end

endmodule

@@ rtl/fmbs_resq.sv @@
// Three-entry result queue taking up to two results a cycle, head at entry zero.
module fmbs_resq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fmbs_pkg::res_push_t            push,
    input  logic                           pop,
    output fmbs_pkg::result_t              head,
    output logic [fmbs_pkg::LEVEL_W-1:0]   level
);

    fmbs_pkg::result_t q_reg   [fmbs_pkg::Q_DEPTH];
    fmbs_pkg::result_t q_next  [fmbs_pkg::Q_DEPTH];
    fmbs_pkg::result_t shifted [fmbs_pkg::Q_DEPTH];
    logic [fmbs_pkg::LEVEL_W-1:0] level_reg, level_next, base;

    always_comb
    begin
        // Advance the queue on a pop, then append behind what remains
        for (int i = 0; i < fmbs_pkg::Q_DEPTH - 1; i++)
        begin
            shifted[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        shifted[fmbs_pkg::Q_DEPTH - 1] = q_reg[fmbs_pkg::Q_DEPTH - 1];
        base = level_reg - {{(fmbs_pkg::LEVEL_W-1){1'b0}}, pop};
        for (int i = 0; i < fmbs_pkg::Q_DEPTH; i++)
        begin
            q_next[i] = shifted[i];
            if (push.v0 && (base == fmbs_pkg::LEVEL_W'(i)))
            begin
                q_next[i] = push.r0;
            end
            if (push.v1 && ((base + fmbs_pkg::LEVEL_W'(1)) == fmbs_pkg::LEVEL_W'(i)))
            begin
                q_next[i] = push.r1;
            end
        end
        level_next = base + {{(fmbs_pkg::LEVEL_W-1){1'b0}}, push.v0}
                          + {{(fmbs_pkg::LEVEL_W-1){1'b0}}, push.v1};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < fmbs_pkg::Q_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign head  = q_reg[0];
    assign level = level_reg;

endmodule

@@ rtl/flac_metadata_block_scanner.sv @@
// Top level of the FLAC metadata block scanner: config register, scan core, result queue.
// Each result is registered in the result queue before it reaches the output.
// Throughput: one byte beat per cycle while the queue has room; a byte can yield two
// results, and the three-entry result queue takes input while at most one result waits.
// Reset: scan returns to the magic check with all counters cleared, stream_length to zero,
// result queue empty.
module flac_metadata_block_scanner (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        stream_start,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] offset,
    output logic [31:0] length,
    output logic        last,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] stream_length
);

    logic [31:0]                   stream_length_reg;
    logic                          in_accept;
    logic                          out_pop;
    logic                          scan_done;
    fmbs_pkg::res_push_t           push;
    fmbs_pkg::result_t             head;
    logic [fmbs_pkg::LEVEL_W-1:0]  level;

    // The register takes a write in any cycle; it does not restart the scan
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            stream_length_reg <= stream_length;
        end
    end

    // Accept a byte beat only while the queue has room for two results,
    // judged from the registered level alone so ready never depends on valid
    assign in_ready  = (level <= fmbs_pkg::LEVEL_W'(fmbs_pkg::Q_DEPTH - 2));
    assign in_accept = in_valid && in_ready;

    // Scan state and decode: all work for one byte sits between the
    // state registers and the queue entries
    fmbs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .stream_start  (stream_start),
        .stream_length (stream_length_reg),
        .push          (push),
        .scan_done     (scan_done)
    );

    // Hold results here until the consumer takes them; the head entry
    // drives the output ports directly
    assign out_pop = out_valid && out_ready;

    fmbs_resq u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_pop),
        .head  (head),
        .level (level)
    );

    assign out_valid = (level != '0);
    assign kind      = head.kind;
    assign offset    = head.offset;
    assign length    = head.length;
    assign last      = head.last;

`ifndef ASSERT_OFF
    // A pair of results is always a comment location followed by the final result
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> (push.v0 && !push.r0.last && push.r1.last))
        else $error("result pair out of order");

    // A stopped scan yields nothing until a restart beat
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !stream_start && scan_done) |-> !push.v0)
        else $error("result after scan stopped");

    // Nothing is pushed without an accepted beat
    a_push_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> in_accept)
        else $error("result pushed without input beat");

    // A pushed result is always held: the queue is never empty the cycle after a push
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |=> (level != '0))
        else $error("result queue lost a result");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the FLAC metadata block scanner: directed and random byte streams.
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        stream_start;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] stream_length;

    // Mirror of the scan state, advanced once per accepted byte beat
    fmbs_pkg::phase_t sc_phase;
    logic [1:0]  sc_idx;
    logic [31:0] sc_pos;
    logic [6:0]  sc_type;
    logic        sc_final;
    logic [23:0] sc_size;
    logic [23:0] sc_skip;
    logic        sc_pics;
    logic        sc_first;
    logic [31:0] sc_len;

    fmbs_pkg::result_t expected_results[$];
    fmbs_pkg::result_t want;
    logic [7:0]  file_bytes[$];

    int          err_count;
    int          bytes_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;

    flac_metadata_block_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .offset       (offset),
        .length       (length),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .stream_length(stream_length)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------

    function automatic void restart_scan();
        sc_phase = fmbs_pkg::PH_MAGIC;
        sc_idx   = 2'd0;
        sc_pos   = 32'd0;
        sc_type  = 7'd0;
        sc_final = 1'b0;
        sc_size  = 24'd0;
        sc_skip  = 24'd0;
        sc_pics  = 1'b0;
        sc_first = 1'b1;
    endfunction

    function automatic void push_result(input logic [2:0] k, input logic [31:0] off,
                                        input logic [31:0] len, input logic fin);
        fmbs_pkg::result_t r;
        r.kind   = k;
        r.offset = off;
        r.length = len;
        r.last   = fin;
        expected_results.push_back(r);
    endfunction

    // Close the scan with the pictures entry or the plain finished marker
    function automatic void close_scan();
        sc_phase = fmbs_pkg::PH_DONE;
        if (sc_pics)
            push_result(fmbs_pkg::KIND_PICTURES, 32'd0, sc_len, 1'b1);
        else
            push_result(fmbs_pkg::KIND_FINISHED, 32'd0, 32'd0, 1'b1);
    endfunction

    function automatic void scan_fail(input logic [31:0] pos);
        sc_phase = fmbs_pkg::PH_DONE;
        push_result(fmbs_pkg::KIND_ERROR, pos, 32'd0, 1'b1);
    endfunction

    // End of a block body: either the metadata is over or the next header follows
    function automatic void block_done(input logic [32:0] nxt);
        if (sc_final || nxt >= {1'b0, sc_len})
            close_scan();
        else
        begin
            sc_phase = fmbs_pkg::PH_HEADER;
            sc_idx   = 2'd0;
        end
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic st);
        logic [31:0] p;
        logic [32:0] nxt;
        longint      room;
        logic        bad_type;
        if (st)
            restart_scan();
        if (sc_phase == fmbs_pkg::PH_DONE)
            return;
        p      = sc_pos;
        nxt    = {1'b0, p} + 33'd1;
        sc_pos = p + 32'd1;
        case (sc_phase)
            fmbs_pkg::PH_MAGIC:
            begin
                if (b != fmbs_pkg::FLAC_MAGIC[sc_idx])
                begin
                    sc_phase = fmbs_pkg::PH_DONE;
                    push_result(fmbs_pkg::KIND_NOT_FLAC, 32'd0, 32'd0, 1'b1);
                    return;
                end
                if (sc_idx == 2'd3)
                begin
                    sc_phase = fmbs_pkg::PH_HEADER;
                    sc_idx   = 2'd0;
                end
                else
                    sc_idx++;
            end
            fmbs_pkg::PH_HEADER:
            begin
                if (sc_idx == 2'd0)
                begin
                    sc_type  = b[6:0];
                    sc_final = b[fmbs_pkg::LAST_BIT_POS];
                    sc_size  = 24'd0;
                    sc_idx   = 2'd1;
                end
                else
                begin
                    sc_size = {sc_size[15:0], b};
                    if (sc_idx != 2'd3)
                        sc_idx++;
                    else
                    begin
                        if (sc_first)
                            bad_type = (sc_type != fmbs_pkg::T_STREAMINFO);
                        else
                            bad_type = (sc_type == fmbs_pkg::T_STREAMINFO) ||
                                       (sc_type == fmbs_pkg::T_INVALID);
                        // signed room left after the header, less the four spare bytes
                        room = longint'(sc_len) - longint'(nxt) - 64'sd4;
                        if (bad_type)
                        begin
                            scan_fail(p - 32'd3);
                            return;
                        end
                        if (longint'(sc_size) > room)
                        begin
                            scan_fail(p - 32'd2);
                            return;
                        end
                        if (!sc_first && sc_type == fmbs_pkg::T_COMMENT)
                            push_result(fmbs_pkg::KIND_COMMENT, nxt[31:0], {8'd0, sc_size},
                                        1'b0);
                        else if (!sc_first && sc_type == fmbs_pkg::T_PICTURE)
                            sc_pics = 1'b1;
                        sc_first = 1'b0;
                        sc_idx   = 2'd0;
                        if (sc_size == 24'd0)
                            block_done(nxt);
                        else
                        begin
                            sc_skip  = sc_size;
                            sc_phase = fmbs_pkg::PH_SKIP;
                        end
                    end
                end
            end
            fmbs_pkg::PH_SKIP:
            begin
                sc_skip = sc_skip - 24'd1;
                if (sc_skip == 24'd0)
                    block_done(nxt);
            end
            default: ;
        endcase
        // Stream runs out before the metadata is complete
        if (sc_phase != fmbs_pkg::PH_DONE && nxt >= {1'b0, sc_len})
        begin
            if (sc_phase == fmbs_pkg::PH_MAGIC)
            begin
                sc_phase = fmbs_pkg::PH_DONE;
                push_result(fmbs_pkg::KIND_NOT_FLAC, 32'd0, 32'd0, 1'b1);
            end
            else
                scan_fail(nxt[31:0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result beat with the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with none pending: kind %0d offset %0d length %0d",
                       kind, offset, length);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    err_count++;
                end
                if (offset !== want.offset)
                begin
                    $error("offset: expected %0d, got %0d", want.offset, offset);
                    err_count++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, length);
                    err_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    err_count++;
                end
            end
        end
    end

    // Receiver: a long hold-off takes priority, otherwise stall at random
    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat on any channel
    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no beat for %0d cycles, %0d results pending", WATCHDOG_LIMIT,
               expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte beat, with random idle cycles in front, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic st);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        stream_start <= st;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        predict_byte(b, st);
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_stream_length(input logic [31:0] value);
        settle();
        @(negedge clk);
        cfg_valid     <= 1'b1;
        stream_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sc_len = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_magic();
        int i;
        file_bytes.delete();
        for (i = 0; i < 4; i++)
            file_bytes.push_back(fmbs_pkg::FLAC_MAGIC[i]);
    endtask

    // Mostly well-formed metadata with random content; some garbage and corrupted bytes
    task automatic build_random_stream();
        int         nblk;
        int         sz;
        int         typ;
        int         pick;
        int         i;
        logic       fin;
        file_bytes.delete();
        if ($urandom_range(99) < 6)
        begin
            sz = $urandom_range(12, 1);
            for (i = 0; i < sz; i++)
            begin
                if (i < 4 && $urandom_range(1) == 1)
                    file_bytes.push_back(fmbs_pkg::FLAC_MAGIC[i]);
                else
                    file_bytes.push_back(8'($urandom));
            end
            return;
        end
        load_magic();
        nblk = $urandom_range(5);
        for (i = 0; i <= nblk; i++)
        begin
            if (i == 0)
                typ = ($urandom_range(99) < 97) ? int'(fmbs_pkg::T_STREAMINFO)
                                                : $urandom_range(127);
            else
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    typ = fmbs_pkg::T_COMMENT;
                else if (pick < 55)
                    typ = fmbs_pkg::T_PICTURE;
                else if (pick < 92)
                    typ = $urandom_range(126, 1);
                else
                    typ = pick[0] ? int'(fmbs_pkg::T_INVALID) : int'(fmbs_pkg::T_STREAMINFO);
            end
            pick = $urandom_range(99);
            if (pick < 80)
                sz = $urandom_range(10);
            else if (pick < 95)
                sz = $urandom_range(60, 11);
            else
                sz = $urandom_range(24'hFF_FFFF, 61);
            fin = (i == nblk) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 4);
            file_bytes.push_back({fin, 7'(typ)});
            file_bytes.push_back(sz[23:16]);
            file_bytes.push_back(sz[15:8]);
            file_bytes.push_back(sz[7:0]);
            // a huge body is never sent in full: stop the stream here
            if (sz > 60)
                break;
            repeat (sz) file_bytes.push_back(8'($urandom));
        end
        // audio frames after the metadata
        repeat ($urandom_range(8)) file_bytes.push_back(8'($urandom));
        if ($urandom_range(99) < 15)
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
    endtask

    function automatic logic [31:0] pick_length(input int n);
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return n;
        else if (pick < 55)
            return n + $urandom_range(300);
        else if (pick < 65)
            return $urandom;
        else if (pick < 70)
            return 32'hFFFF_FFFF;
        else if (pick < 95)
            return $urandom_range(n, 1);
        return 32'd0;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset length is zero: the first magic byte already ends the stream
    task automatic test_reset_length();
        send_byte(8'h66, 1'b1);
        // scan has stopped: drop this one
        send_byte(8'h4C, 1'b0);
    endtask

    // Type 127 with the last flag as the first block, at the widest length
    task automatic test_bad_first_type();
        write_stream_length(32'hFFFF_FFFF);
        load_magic();
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        send_stream();
    endtask

    // Largest block size against a short stream
    task automatic test_oversized_block();
        write_stream_length(32'd100);
        load_magic();
        file_bytes.push_back({1'b0, fmbs_pkg::T_STREAMINFO});
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        send_stream();
    endtask

    // STREAMINFO, a comment block with a body, then a last empty picture block
    task automatic test_comment_and_pictures();
        write_stream_length(32'hFFFF_FFFF);
        load_magic();
        file_bytes.push_back({1'b0, fmbs_pkg::T_STREAMINFO});
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back({1'b0, fmbs_pkg::T_COMMENT});
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h02);
        file_bytes.push_back(8'hAA);
        file_bytes.push_back(8'h55);
        file_bytes.push_back({1'b1, fmbs_pkg::T_PICTURE});
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        send_stream();
    endtask

    // Shorten the stream while inside a block body
    task automatic test_length_cut_in_body();
        write_stream_length(32'd1000);
        load_magic();
        file_bytes.push_back({1'b0, fmbs_pkg::T_STREAMINFO});
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h0A);
        repeat (3) file_bytes.push_back(8'($urandom));
        send_stream();
        write_stream_length(32'd12);
        send_byte(8'h5A, 1'b0);
    endtask

    // Hold the receiver off so the result queue fills and stalls the input,
    // then pause the sender until everything has drained
    task automatic test_backpressure();
        logic [7:0] b;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        hold_cycles = 300;
        repeat (24)
        begin
            b = 8'($urandom);
            if (b == fmbs_pkg::FLAC_MAGIC[0])
                b = 8'h00;
            send_byte(b, 1'b1);
        end
        settle();
    endtask

    task automatic test_random_streams(input int send_pct, input int recv_pct, input int quota);
        int          goal;
        int          split;
        int          i;
        logic [31:0] len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        goal = bytes_sent + quota;
        while (bytes_sent < goal)
        begin
            build_random_stream();
            len = pick_length(file_bytes.size());
            if (len != sc_len || $urandom_range(9) == 0)
                write_stream_length(len);
            split = ($urandom_range(99) < 10) ? $urandom_range(file_bytes.size() - 1) : 0;
            for (i = 0; i < file_bytes.size(); i++)
            begin
                // move the end of the stream to just around the current position
                if (split != 0 && i == split)
                    write_stream_length(sc_pos + $urandom_range(3));
                send_byte(file_bytes[i], i == 0 || $urandom_range(99) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'd0;
        stream_start   = 1'b0;
        cfg_valid      = 1'b0;
        stream_length  = 32'd0;
        err_count      = 0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        sc_len         = 32'd0;
        restart_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_bad_first_type();
        test_oversized_block();
        test_comment_and_pictures();
        test_length_cut_in_body();
        test_backpressure();
        test_random_streams(0, 0, 360);
        test_random_streams(85, 0, 400);
        test_random_streams(0, 85, 400);
        test_random_streams(30, 30, 400);

        settle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
